FILE: hdl/midt_pkg.sv
// ----------------------------------------------------------------------------
// midt_pkg - shared types and constants for the message ID dedup table
// Holds the action codes, the sequencer state type and the default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package midt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 64;

    // Fixed widths of the stream fields
    localparam int ACTION_W  = 2;
    localparam int MSG_KEY_W = 64;
    localparam int S_DATA_W  = 72;   // action + msg_key, padded to bytes
    localparam int M_DATA_W  = 8;    // found + pending + inserted, padded

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/message_id_dedup_table.sv
// ----------------------------------------------------------------------------
// message_id_dedup_table - bounded table of message IDs for duplicate checks
// Each item adds, marks done or queries a key. One stored key is compared per
// cycle against the item's key; new keys replace the oldest entry when full.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                 | handshake
//  --------+-----+-------------------------------------------+----------------
//  s       | in  | action[1:0], msg_key[65:2], zero [71:66]  | tvalid / tready
//  m       | out | found[0], pending[1], inserted[2], zero   | tvalid / tready
//
//  The single key comparator walks the key memory one entry a cycle.
//  Reset clears the valid and pending bits at once; no clearing pass.
//  A result waits in the output register; the next item is accepted meanwhile,
//  and only the end of the following item stalls while that result is held.
//
`default_nettype none

module message_id_dedup_table #(
    parameter int TABLE_DEPTH = midt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = midt_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // action[1:0], msg_key[65:2], zero fill [71:66]
    input  wire logic [midt_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // found[0], pending[1], inserted[2], zero fill [7:3]
    output logic [midt_pkg::M_DATA_W-1:0]      o_m_tdata
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    midt_pkg::t_state r_state, n_state;

    logic [KEY_BITS-1:0]            r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]         r_valid, n_valid;
    logic [TABLE_DEPTH-1:0]         r_pending, n_pending;
    logic [SLOT_W-1:0]              r_oldest, n_oldest;

    logic [midt_pkg::ACTION_W-1:0]  r_action;
    logic [KEY_BITS-1:0]            r_key;
    logic [SLOT_W-1:0]              r_idx, n_idx;
    logic [KEY_BITS-1:0]            r_rd_key;
    logic [SLOT_W-1:0]              r_rd_slot;
    logic                           r_rd_vld;
    logic                           r_hit, n_hit;
    logic [SLOT_W-1:0]              r_hit_slot, n_hit_slot;

    logic                           r_m_valid;
    logic                           r_found, r_pend, r_ins;

    logic                           accept;
    logic                           rd_en;
    logic                           finish_go;
    logic                           match;
    logic                           do_insert;

    assign accept = i_s_tvalid && o_s_tready;
    assign match  = r_rd_vld && r_valid[r_rd_slot] && (r_rd_key == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            midt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = midt_pkg::S_SCAN;
                end
            end
            midt_pkg::S_SCAN: begin
                if (r_idx == LAST_SLOT) begin
                    n_state = midt_pkg::S_DRAIN;
                end
            end
            midt_pkg::S_DRAIN: begin
                n_state = midt_pkg::S_FINISH;
            end
            midt_pkg::S_FINISH: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = midt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = midt_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        rd_en      = 1'b0;
        finish_go  = 1'b0;
        case (r_state)
            midt_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
            end
            midt_pkg::S_SCAN: begin
                rd_en = 1'b1;
            end
            midt_pkg::S_DRAIN: begin
                rd_en = 1'b0;
            end
            midt_pkg::S_FINISH: begin
                finish_go = !r_m_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign do_insert = finish_go && (r_action == midt_pkg::ACT_ADD) && !r_hit;

    // scan index and hit tracking
    always_comb begin
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_slot = r_hit_slot;
        if (accept) begin
            n_idx = '0;
            n_hit = 1'b0;
        end else if (rd_en && (r_idx != LAST_SLOT)) begin
            n_idx = r_idx + 1'b1;
        end
        if (match) begin
            n_hit      = 1'b1;
            n_hit_slot = r_rd_slot;
        end
    end

    // table flag and ring pointer updates
    always_comb begin
        n_valid   = r_valid;
        n_pending = r_pending;
        n_oldest  = r_oldest;
        if (do_insert) begin
            n_valid[r_oldest]   = 1'b1;
            n_pending[r_oldest] = 1'b1;
            n_oldest = (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
        end else if (finish_go && (r_action == midt_pkg::ACT_DONE) && r_hit) begin
            n_pending[r_hit_slot] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= midt_pkg::S_IDLE;
            r_valid   <= '0;
            r_pending <= '0;
            r_oldest  <= '0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_pending <= n_pending;
            r_oldest  <= n_oldest;
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_rd_vld  <= rd_en;
            if (finish_go) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hit_slot <= n_hit_slot;
        if (accept) begin
            r_action <= i_s_tdata[midt_pkg::ACTION_W-1:0];
            r_key    <= i_s_tdata[midt_pkg::ACTION_W +: KEY_BITS];
        end
        if (finish_go) begin
            r_found <= r_hit;
            r_pend  <= r_hit && r_pending[r_hit_slot];
            r_ins   <= (r_action == midt_pkg::ACT_ADD) && !r_hit;
        end
    end

    // key memory: one read port for the scan, one write port for inserts
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key  <= r_mem[r_idx];
            r_rd_slot <= r_idx;
        end
        if (do_insert) begin
            r_mem[r_oldest] <= r_key;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(midt_pkg::M_DATA_W - 3){1'b0}}, r_ins, r_pend, r_found};

    // checks
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == midt_pkg::S_SCAN))
        else $error("accepted item did not start a scan");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == midt_pkg::S_FINISH && r_hit) |-> r_valid[r_hit_slot])
        else $error("hit recorded on an invalid slot");

    a_insert_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_ins && r_found))
        else $error("insert reported for a key already present");

    a_pending_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (!r_pend || r_found))
        else $error("pending reported without a match");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_go |=> (r_m_valid && r_state == midt_pkg::S_IDLE))
        else $error("finished item did not load the result register");

endmodule

`default_nettype wire
